FILE: rtl/core/rss_pkg.sv
// Shared types, codes and compare functions for the record sorter.
// Used by rss_cell, record_sorter_by_selectable_key_unit and the testbench; no dependencies.
package rss_pkg;

    // Field widths fixed by the record format
    localparam int GRADE_W    = 10;
    localparam int YEAR_W     = 4;
    localparam int TAG_W      = 16;
    localparam int KEY_W      = 10;
    localparam int REC_W      = GRADE_W + YEAR_W + TAG_W;
    localparam int TDATA_W    = ((REC_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam int MAX_RECORDS_DEF = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT = 1'd1;

    // Key select codes
    localparam logic KEY_GRADE = 1'b0;
    localparam logic KEY_YEAR  = 1'b1;

    // Cell operating modes
    localparam logic [1:0] MODE_HOLD  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_SORT  = 2'd2;
    localparam logic [1:0] MODE_SHIFT = 2'd3;

    // One record, grade in the lowest bits
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [YEAR_W-1:0]  year;
        logic [GRADE_W-1:0] grade;
    } record_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic [1:0] mode;
        logic       parity;
        logic       descending;
        logic       key_select;
    } cell_ctl_t;

    function automatic logic [KEY_W-1:0] rec_key(input record_t r, input logic key_sel);
        logic [KEY_W-1:0] k;
        if (key_sel == KEY_YEAR) begin
            k = {{(KEY_W-YEAR_W){1'b0}}, r.year};
        end else begin
            k = r.grade;
        end
        return k;
    endfunction

    // True when a (earlier slot) must move behind b; strict, so equal keys stay put
    function automatic logic out_of_order(input record_t a, input record_t b,
                                          input logic desc, input logic key_sel);
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        ka = rec_key(a, key_sel);
        kb = rec_key(b, key_sel);
        return desc ? (ka < kb) : (ka > kb);
    endfunction

endpackage

FILE: rtl/core/rss_cell.sv
// One cell of the sorting row: holds a record, loads it, compare-swaps with a
// neighbor during odd-even transposition, and shifts toward cell 0 on output.
// Depends on rss_pkg.
module rss_cell
    import rss_pkg::*;
#(
    parameter int IDX  = 0,
    parameter int CntW = 7
) (
    input  logic            aclk,
    input  cell_ctl_t       ctl,
    input  logic [CntW-1:0] count,
    input  record_t         load_rec,
    input  record_t         left_rec,
    input  record_t         right_rec,
    output record_t         rec
);

    localparam logic [CntW-1:0] MY_IDX   = CntW'(IDX);
    localparam logic [CntW-1:0] NEXT_IDX = CntW'(IDX + 1);
    localparam logic            MY_PAR   = 1'(IDX % 2);

    record_t cell_rec_reg;
    record_t cell_rec_next;
    logic    is_left;
    logic    is_right;

    // Pair role in the current phase; only slots below count take part
    assign is_left  = (MY_PAR == ctl.parity) && (NEXT_IDX < count);
    assign is_right = (MY_PAR != ctl.parity) && (IDX != 0) && (MY_IDX < count);

    always_comb begin
        cell_rec_next = cell_rec_reg;
        case (ctl.mode)
            MODE_LOAD: begin
                if (count == MY_IDX) begin
                    cell_rec_next = load_rec;
                end
            end
            MODE_SORT: begin
                if (is_left && out_of_order(cell_rec_reg, right_rec,
                                            ctl.descending, ctl.key_select)) begin
                    cell_rec_next = right_rec;
                end else if (is_right && out_of_order(left_rec, cell_rec_reg,
                                                      ctl.descending, ctl.key_select)) begin
                    cell_rec_next = left_rec;
                end
            end
            MODE_SHIFT: begin
                cell_rec_next = right_rec;
            end
            default: begin
                cell_rec_next = cell_rec_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cell_rec_reg <= cell_rec_next;
    end

    assign rec = cell_rec_reg;

endmodule

FILE: rtl/core/record_sorter_by_selectable_key_unit.sv
// Top level of the record sorter: control, configuration and the row of cells.
// Depends on rss_pkg and rss_cell.

// Records arrive one per cycle while the block is loading, into a row of
// MAX_RECORDS cells, each cell taking the record whose arrival slot matches
// its position. The item with tlast starts an odd-even transposition sort
// over the n stored records, one compare-swap phase per cycle across all
// cell pairs at once, with equal keys never swapped so arrival order holds
// among them. The row then shifts toward cell 0 and delivers one item per
// cycle while m_tready is high. A set is loaded, then sorted, then delivered
// before the next set is taken. The sort key and order are sampled when the
// tlast item is accepted. Records beyond MAX_RECORDS are dropped and m_tuser
// is high on every item of that set. No input is taken while a set is sorted
// or delivered; the block needs no clearing pass after reset.
module record_sorter_by_selectable_key_unit
    import rss_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input records
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // grade_hundredths, study_year, record_tag, zeros
    input  logic                  s_tlast,   // last_in
    // sorted records
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // out_grade, out_year, out_tag, zeros
    output logic                  m_tlast,   // last_out
    output logic                  m_tuser,   // overflow
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] phase_reg, phase_next;
    logic             dropped_reg, dropped_next;
    logic             desc_cfg_reg, key_cfg_reg;
    logic             desc_lock_reg, desc_lock_next;
    logic             key_lock_reg, key_lock_next;

    logic             in_acc;
    logic             out_acc;
    logic [1:0]       mode;
    cell_ctl_t        ctl;
    record_t          in_rec;
    record_t          cell_rec [MAX_RECORDS];

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    assign in_rec.grade = s_tdata[GRADE_W-1:0];
    assign in_rec.year  = s_tdata[GRADE_W+YEAR_W-1:GRADE_W];
    assign in_rec.tag   = s_tdata[REC_W-1:GRADE_W+YEAR_W];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desc_cfg_reg <= 1'b0;
            key_cfg_reg  <= KEY_GRADE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DESCENDING: desc_cfg_reg <= cfg_data[0];
                CFG_KEY_SELECT: key_cfg_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Load / sort / emit sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        dropped_next   = dropped_reg;
        desc_lock_next = desc_lock_reg;
        key_lock_next  = key_lock_reg;
        mode           = MODE_HOLD;
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (in_acc) begin
                    if (count_reg < CAP) begin
                        mode       = MODE_LOAD;
                        count_next = count_reg + ONE;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next     = ST_SORT;
                        phase_next     = '0;
                        desc_lock_next = desc_cfg_reg;
                        key_lock_next  = key_cfg_reg;
                    end
                end
            end
            ST_SORT: begin
                mode       = MODE_SORT;
                phase_next = phase_reg + ONE;
                if (phase_reg == count_reg - ONE) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    mode       = MODE_SHIFT;
                    count_next = count_reg - ONE;
                    if (count_reg == ONE) begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            phase_reg     <= '0;
            dropped_reg   <= 1'b0;
            desc_lock_reg <= 1'b0;
            key_lock_reg  <= KEY_GRADE;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            dropped_reg   <= dropped_next;
            desc_lock_reg <= desc_lock_next;
            key_lock_reg  <= key_lock_next;
        end
    end

    assign ctl.mode       = mode;
    assign ctl.parity     = phase_reg[0];
    assign ctl.descending = desc_lock_reg;
    assign ctl.key_select = key_lock_reg;

    // Row of cells; the ends see their own record as the missing neighbor
    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        record_t left_rec;
        record_t right_rec;
        if (i == 0) begin : g_lend
            assign left_rec = cell_rec[i];
        end else begin : g_lmid
            assign left_rec = cell_rec[i-1];
        end
        if (i == MAX_RECORDS - 1) begin : g_rend
            assign right_rec = cell_rec[i];
        end else begin : g_rmid
            assign right_rec = cell_rec[i+1];
        end
        rss_cell #(
            .IDX  (i),
            .CntW (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .count     (count_reg),
            .load_rec  (in_rec),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .rec       (cell_rec[i])
        );
    end

    // Output item comes from the head cell
    assign m_tdata = {{(TDATA_W-REC_W){1'b0}}, cell_rec[0]};
    assign m_tlast = (count_reg == ONE);
    assign m_tuser = dropped_reg;

    // Checks
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == ST_EMIT) && (count_reg != '0))
        else $error("emitting with an empty row");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while results are delivered");

    a_clear_after_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && m_tlast) |=> (count_reg == '0) && !dropped_reg && s_tready)
        else $error("set not cleared after its last item");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("record count beyond capacity");

endmodule

FILE: verif/record_sorter_checker.sv
// Scoreboard for the record sorter: watches the record, result and config channels,
// predicts each sorted burst and compares it item by item. Depends on rss_pkg.
module record_sorter_checker
    import rss_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // grade_hundredths, study_year, record_tag, zeros
    input  logic                  s_tlast,   // last_in
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,   // out_grade, out_year, out_tag, zeros
    input  logic                  m_tlast,   // last_out
    input  logic                  m_tuser,   // overflow
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    results_checked,
    output int                    sets_sorted,
    output int                    overflow_sets
);

    // One expected item of a sorted burst
    typedef struct {
        record_t rec;
        logic    last;
        logic    dropped;
    } sorted_rec_t;

    record_t     set_buf [MAX_RECORDS];
    int          set_len;
    logic        set_dropped;
    logic        desc_q;
    logic        by_year_q;
    sorted_rec_t sorted_q [$];

    function automatic logic [GRADE_W-1:0] sort_key(input record_t r);
        return by_year_q ? {{(GRADE_W-YEAR_W){1'b0}}, r.year} : r.grade;
    endfunction

    // Strict compare keeps equal keys in arrival order
    function automatic logic must_follow(input record_t a, input record_t b);
        return desc_q ? (sort_key(a) < sort_key(b)) : (sort_key(a) > sort_key(b));
    endfunction

    // Stable insertion sort of the stored set, then queue the burst
    function automatic void queue_sorted_set();
        record_t     order [MAX_RECORDS];
        record_t     tmp;
        sorted_rec_t item;
        int          i;
        int          j;
        for (i = 0; i < set_len; i++) order[i] = set_buf[i];
        for (i = 1; i < set_len; i++) begin
            j = i;
            while (j > 0 && must_follow(order[j-1], order[j])) begin
                tmp        = order[j-1];
                order[j-1] = order[j];
                order[j]   = tmp;
                j--;
            end
        end
        for (i = 0; i < set_len; i++) begin
            item.rec     = order[i];
            item.last    = (i == set_len - 1);
            item.dropped = set_dropped;
            sorted_q.insert(sorted_q.size(), item);
        end
    endfunction

    function automatic void take_record();
        if (set_len < MAX_RECORDS) begin
            set_buf[set_len] = s_tdata[REC_W-1:0];
            set_len++;
        end else begin
            set_dropped = 1'b1;
        end
        if (s_tlast) begin
            queue_sorted_set();
            sets_sorted++;
            if (set_dropped) overflow_sets++;
            set_len     = 0;
            set_dropped = 1'b0;
        end
    endfunction

    function automatic void check_delivery();
        record_t     got;
        sorted_rec_t want;
        got = m_tdata[REC_W-1:0];
        results_checked++;
        if (sorted_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected item: grade %0d year %0d tag %h last %b ovf %b",
                         got.grade, got.year, got.tag, m_tlast, m_tuser);
            return;
        end
        want = sorted_q.pop_front();
        if (got.grade !== want.rec.grade || got.year !== want.rec.year ||
            got.tag !== want.rec.tag || m_tlast !== want.last || m_tuser !== want.dropped) begin
            fail_count++;
            if (fail_count <= 10)
                $display("item %0d mismatch: expected grade %0d year %0d tag %h last %b ovf %b,",
                         results_checked, want.rec.grade, want.rec.year, want.rec.tag,
                         want.last, want.dropped,
                         " got grade %0d year %0d tag %h last %b ovf %b",
                         got.grade, got.year, got.tag, m_tlast, m_tuser);
        end
    endfunction

    // Config first, results before records: a burst never ends at the edge its set closes
    always @(posedge aclk) begin
        if (!aresetn) begin
            sorted_q.delete();
            set_len     = 0;
            set_dropped = 1'b0;
            desc_q      = 1'b0;
            by_year_q   = KEY_GRADE;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DESCENDING: desc_q = cfg_data[0];
                    CFG_KEY_SELECT: by_year_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) check_delivery();
            if (s_tvalid && s_tready) take_record();
        end
        pending <= sorted_q.size();
    end

endmodule

FILE: verif/tb_top.sv
// Top of the record sorter testbench: clock, reset, record and config stimulus,
// random back-pressure and the verdict. Depends on rss_pkg, the unit and record_sorter_checker.
module tb_top;
    import rss_pkg::*;

    localparam int          MAX_REC     = MAX_RECORDS_DEF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 10;
    // Per random phase: sort order and key
    localparam logic [4:0]  PHASE_DESC    = 5'b11010;
    localparam logic [4:0]  PHASE_BY_YEAR = 5'b01100;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int sets_sorted;
    int overflow_sets;
    int cycles;
    int records_sent;
    bit tx_steady;
    bit hold_armed;
    bit hold_done;

    record_sorter_by_selectable_key_unit #(.MAX_RECORDS(MAX_REC)) dut (.*);

    record_sorter_checker #(.MAX_RECORDS(MAX_REC)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected", cycles, pending);
            $display("FAIL record_sorter_by_selectable_key_unit");
            $finish;
        end
    end

    // Result side: random ready runs and stalls, plus one long hold-off on request
    initial begin
        int unsigned run;
        int unsigned stall;
        int unsigned r;
        m_tready = 1'b0;
        forever begin
            if (hold_armed && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
                m_tready <= 1'b1;
                // a requested hold-off cuts the ready run short
                for (int unsigned k = 0; k < run; k++) begin
                    if (hold_armed && !hold_done) break;
                    @(posedge aclk);
                end
                r = $urandom_range(0, 99);
                stall = (r < 70) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(5, 30);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic record_t make_record(input logic [GRADE_W-1:0] g,
                                            input logic [YEAR_W-1:0] y,
                                            input logic [TAG_W-1:0] t);
        record_t rec;
        rec.grade = g;
        rec.year  = y;
        rec.tag   = t;
        return rec;
    endfunction

    // Narrow grade ranges now and then to force ties; full 10 bits otherwise
    function automatic record_t random_record();
        int unsigned r;
        logic [GRADE_W-1:0] g;
        r = $urandom_range(0, 99);
        if (r < 25)      g = GRADE_W'($urandom_range(0, 3));
        else if (r < 35) g = GRADE_W'($urandom_range(990, 1023));
        else             g = GRADE_W'($urandom_range(0, 1023));
        return make_record(g, YEAR_W'($urandom_range(0, 15)),
                           TAG_W'($urandom_range(0, 65535)));
    endfunction

    task automatic send_record(input record_t rec, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-REC_W){1'b0}}, rec};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        records_sent++;
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) send_record(random_record(), i == n - 1);
    endtask

    // Sender pauses until every sorted item has come out, then lets the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_sort(input logic desc, input logic by_year);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DESCENDING;
        cfg_data  <= desc;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_KEY_SELECT;
        cfg_data  <= by_year;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int start;
        int n;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DESCENDING;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: ascending grade. Single-record set with field maxima.
        send_record(make_record(10'd1000, 4'd15, 16'hFFFF), 1'b1);
        // Extremes, a grade above 1000 and three equal grades
        send_record(make_record(10'd500, 4'd3, 16'h1111), 1'b0);
        send_record(make_record(10'd0, 4'd0, 16'h0000), 1'b0);
        send_record(make_record(10'd1023, 4'd15, 16'hFFFF), 1'b0);
        send_record(make_record(10'd500, 4'd7, 16'h2222), 1'b0);
        send_record(make_record(10'd1000, 4'd1, 16'hABCD), 1'b0);
        send_record(make_record(10'd1, 4'd8, 16'h5555), 1'b0);
        send_record(make_record(10'd500, 4'd0, 16'h3333), 1'b1);

        // Descending year with ties
        program_sort(1'b1, KEY_YEAR);
        send_record(make_record(10'd10, 4'd5, 16'h0101), 1'b0);
        send_record(make_record(10'd20, 4'd15, 16'h0202), 1'b0);
        send_record(make_record(10'd30, 4'd5, 16'h0303), 1'b0);
        send_record(make_record(10'd40, 4'd0, 16'h0404), 1'b0);
        send_record(make_record(10'd50, 4'd15, 16'h0505), 1'b0);
        send_record(make_record(10'd60, 4'd5, 16'h0606), 1'b1);

        // Ascending year
        program_sort(1'b0, KEY_YEAR);
        send_record(make_record(10'd900, 4'd9, 16'hAAAA), 1'b0);
        send_record(make_record(10'd100, 4'd2, 16'h5555), 1'b0);
        send_record(make_record(10'd800, 4'd9, 16'h00FF), 1'b0);
        send_record(make_record(10'd700, 4'd2, 16'hFF00), 1'b1);

        // Descending grade, equal keys around an out-of-range grade
        program_sort(1'b1, KEY_GRADE);
        send_record(make_record(10'd5, 4'd0, 16'h0001), 1'b0);
        send_record(make_record(10'd1023, 4'd0, 16'h0002), 1'b0);
        send_record(make_record(10'd5, 4'd0, 16'h0003), 1'b1);

        // Random sets, one setting per phase
        for (int ph = 0; ph < 5; ph++) begin
            program_sort(PHASE_DESC[ph], PHASE_BY_YEAR[ph]);
            tx_steady = (ph % 2 == 1);
            // long receiver hold-off while a full store loads and more records wait
            if (ph == 1) hold_armed = 1'b1;
            // a full store, then a set that overflows it
            if (ph == 1) send_set(MAX_REC);
            if (ph == 2) send_set(MAX_REC + int'($urandom_range(1, 6)));
            start = records_sent;
            while (records_sent - start < PHASE_ITEMS) begin
                n = ($urandom_range(0, 99) < 85) ? int'($urandom_range(1, 8))
                                                 : int'($urandom_range(9, 24));
                send_set(n);
            end
        end

        // Drain, then give the block time to show any stray item
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (2 * MAX_REC + 16) @(posedge aclk);

        if (pending != 0) $display("%0d sorted items never delivered", pending);
        $display("Sent %0d records in %0d sets (%0d overflowed); checked %0d sorted items",
                 records_sent, sets_sorted, overflow_sets, results_checked);
        $display("over both keys, both orders, ties, a full store and a long output stall");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS record_sorter_by_selectable_key_unit");
        end else begin
            $display("FAIL record_sorter_by_selectable_key_unit");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/rss_pkg.sv
rtl/core/rss_cell.sv
rtl/core/record_sorter_by_selectable_key_unit.sv
verif/record_sorter_checker.sv
verif/tb_top.sv
